>>> src/ffr_pkg.sv
// ----------------------------------------------------------------------------
// ffr_pkg: shared types and codes of the firmware frame receiver
//
// Item and result layouts, status and operation codes, and the
// configuration register indexes used across the receiver modules.
// ----------------------------------------------------------------------------
package ffr_pkg;

  // Field widths fixed by the frame format
  localparam int unsigned FNUM_W   = 16;
  localparam int unsigned FLEN_W   = 11;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 19;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned OFFS_W   = 10;
  localparam int unsigned STATUS_W = 3;

  // Stream packing widths
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 48;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SUM    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_STRIDE = 2'd2;

  localparam logic [FLEN_W-1:0] FRAME_STRIDE_RESET = 11'd1024;

  // Operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK           = 3'd0,
    STAT_DUPLICATE    = 3'd1,
    STAT_SEQ_ERROR    = 3'd2,
    STAT_TOO_LARGE    = 3'd3,
    STAT_SUM_MISMATCH = 3'd4,
    STAT_COMPLETE     = 3'd5
  } ffr_status_t;

  typedef struct packed {
    logic [LEN_W-1:0]  image_length;
    logic [SUM_W-1:0]  image_sum;
    logic [FLEN_W-1:0] frame_stride;
  } ffr_cfg_t;

  typedef struct packed {
    logic              operation;
    logic [FNUM_W-1:0] frame_number;
    logic [FLEN_W-1:0] frame_length;
    logic [BYTE_W-1:0] byte_value;
    logic              last_in_frame;
  } ffr_item_t;

  typedef struct packed {
    logic              write_enable;
    logic [ADDR_W-1:0] write_address;
    logic [BYTE_W-1:0] write_data;
    ffr_status_t       status;
  } ffr_result_t;

endpackage

>>> src/ffr_cfg.sv
// ----------------------------------------------------------------------------
// ffr_cfg: configuration registers
//
// Holds image length, expected image sum and frame stride. Writes to an
// index outside the register list are taken and dropped.
// ----------------------------------------------------------------------------
module ffr_cfg
  import ffr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output ffr_cfg_t              cfg
);

  ffr_cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg         = regs;

  // Write the addressed register on each beat
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.image_length <= '0;
      regs.image_sum    <= '0;
      regs.frame_stride <= FRAME_STRIDE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IMAGE_LENGTH: regs.image_length <= cfg_data[LEN_W-1:0];
        CFG_IMAGE_SUM:    regs.image_sum    <= cfg_data[SUM_W-1:0];
        CFG_FRAME_STRIDE: regs.frame_stride <= cfg_data[FLEN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> src/ffr_in_stage.sv
// ----------------------------------------------------------------------------
// ffr_in_stage: input register
//
// Captures one input beat and holds it until the core takes it; a new
// beat is accepted in the same cycle the held one moves on.
// ----------------------------------------------------------------------------
module ffr_in_stage
  import ffr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,
  input  logic [0:0]            s_tuser,
  input  logic                  s_tlast,
  input  logic                  take,
  output logic                  item_valid,
  output ffr_item_t             item
);

  logic      valid;
  ffr_item_t held;

  assign s_tready   = !valid || take;
  assign item_valid = valid;
  assign item       = held;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      held.operation     <= s_tuser[0];
      held.frame_number  <= s_tdata[15:0];
      held.frame_length  <= s_tdata[26:16];
      held.byte_value    <= s_tdata[34:27];
      held.last_in_frame <= s_tlast;
    end
  end

endmodule

>>> src/ffr_core.sv
// ----------------------------------------------------------------------------
// ffr_core: frame sequencing, byte count, sum and write address
//
// Checks the frame number against the expected one, tracks length, sum
// and offset within the frame, and forms the result of one beat.
// ----------------------------------------------------------------------------
module ffr_core
  import ffr_pkg::*;
#(
  parameter int unsigned       MAX_IMAGE_BYTES = 262144,
  parameter logic [ADDR_W-1:0] BASE_ADDRESS    = 32'h0000_0000,
  parameter int unsigned       MAX_FRAME_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  ffr_cfg_t    cfg,
  input  logic        item_valid,
  input  ffr_item_t   item,
  input  logic        out_ready,
  output logic        take,
  output ffr_result_t result
);

  localparam logic [31:0] MAX_IMG_W   = 32'(MAX_IMAGE_BYTES);
  localparam logic [31:0] MAX_FRAME_W = 32'(MAX_FRAME_BYTES);
  localparam int unsigned PROD_W      = FNUM_W + FLEN_W;

  logic [FNUM_W-1:0] expected_frame, expected_frame_next;
  logic [SUM_W-1:0]  running_sum, running_sum_next;
  logic [LEN_W-1:0]  received_length, received_length_next;
  logic [OFFS_W-1:0] byte_offset, byte_offset_next;
  logic              frame_blocked, frame_blocked_next;
  logic              frame_open, frame_open_next;

  logic              start_bad;
  logic              frame_nonzero;
  logic [LEN_W:0]    len_sum;
  logic [LEN_W-1:0]  len_upd;
  logic              blocked_now;
  logic [SUM_W-1:0]  sum_upd;
  logic [PROD_W-1:0] frame_base;

  assign take = item_valid && out_ready;

  // Start is refused when the limits exceed the build-time maxima
  assign start_bad = ({13'd0, cfg.image_length} > MAX_IMG_W) ||
                     ({21'd0, cfg.frame_stride} > MAX_FRAME_W);

  assign frame_nonzero = (item.frame_number != '0);

  // Saturating length add on the first byte of a frame other than frame 0
  assign len_sum = {1'b0, received_length} + {9'd0, item.frame_length};
  always_comb begin
    len_upd = received_length;
    if (!frame_open && frame_nonzero) begin
      len_upd = len_sum[LEN_W] ? '1 : len_sum[LEN_W-1:0];
    end
  end

  assign blocked_now = frame_open ? frame_blocked : ({13'd0, len_upd} > MAX_IMG_W);
  assign sum_upd     = frame_nonzero ? running_sum + {24'd0, item.byte_value} : running_sum;
  assign frame_base  = PROD_W'(expected_frame) * PROD_W'(cfg.frame_stride);

  // Next state and result of one beat
  always_comb begin
    expected_frame_next  = expected_frame;
    running_sum_next     = running_sum;
    received_length_next = received_length;
    byte_offset_next     = byte_offset;
    frame_blocked_next   = frame_blocked;
    frame_open_next      = frame_open;
    result               = '0;
    result.status        = STAT_OK;

    case (item.operation)
      OP_START: begin
        if (start_bad) begin
          result.status = STAT_TOO_LARGE;
        end else begin
          expected_frame_next  = '0;
          running_sum_next     = '0;
          received_length_next = '0;
          byte_offset_next     = '0;
          frame_blocked_next   = 1'b0;
          frame_open_next      = 1'b0;
        end
      end
      OP_DATA: begin
        if (item.frame_number < expected_frame) begin
          result.status = STAT_DUPLICATE;
        end else if (item.frame_number > expected_frame) begin
          result.status = STAT_SEQ_ERROR;
        end else begin
          received_length_next = len_upd;
          running_sum_next     = sum_upd;
          if (blocked_now) begin
            result.status = STAT_TOO_LARGE;
          end else begin
            result.write_enable  = 1'b1;
            result.write_data    = item.byte_value;
            result.write_address = BASE_ADDRESS + ADDR_W'(frame_base) +
                                   ADDR_W'(byte_offset);
          end
          if (item.last_in_frame) begin
            if (!blocked_now) begin
              expected_frame_next = expected_frame + 1'b1;
              if (len_upd >= cfg.image_length) begin
                result.status = (sum_upd == cfg.image_sum) ? STAT_COMPLETE
                                                           : STAT_SUM_MISMATCH;
              end
            end
            byte_offset_next   = '0;
            frame_blocked_next = 1'b0;
            frame_open_next    = 1'b0;
          end else begin
            byte_offset_next   = byte_offset + 1'b1;
            frame_blocked_next = blocked_now;
            frame_open_next    = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Advance state when the beat moves to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_frame  <= '0;
      running_sum     <= '0;
      received_length <= '0;
      byte_offset     <= '0;
      frame_blocked   <= 1'b0;
      frame_open      <= 1'b0;
    end else if (take) begin
      expected_frame  <= expected_frame_next;
      running_sum     <= running_sum_next;
      received_length <= received_length_next;
      byte_offset     <= byte_offset_next;
      frame_blocked   <= frame_blocked_next;
      frame_open      <= frame_open_next;
    end
  end

endmodule

>>> src/ffr_out_stage.sv
// ----------------------------------------------------------------------------
// ffr_out_stage: result register
//
// Holds one result beat on the output stream until it is taken, and
// reloads in the same cycle the held beat leaves.
// ----------------------------------------------------------------------------
module ffr_out_stage
  import ffr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  ffr_result_t            result,
  output logic                   out_ready,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  logic        valid;
  ffr_result_t held;

  assign out_ready = !valid || m_tready;
  assign m_tvalid  = valid;
  assign m_tdata   = {4'd0, held.status, held.write_data, held.write_address,
                      held.write_enable};

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (out_ready) begin
      valid <= load;
    end
  end

  // Capture the result
  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

>>> src/firmware_frame_receiver.sv
// ----------------------------------------------------------------------------
// firmware_frame_receiver: numbered-frame firmware image receiver
//
// Takes one image byte per beat and returns one result beat per input beat.
// ----------------------------------------------------------------------------
// Each input beat passes through an input register and, after one stage of
// logic (a 16x11 frame-stride multiply with address add, sum and length
// update), a result register, so a byte enters every cycle while the output
// is not stalled, and its result is presented once the beat moves from the
// input register into the result register. Frame state (expected frame,
// running sum, byte count, offset) updates as a beat moves into the result
// register, so back-to-back bytes see each other's effect. Configuration is
// written through the cfg port, which is always ready; write it only while
// no beat is in flight.
module firmware_frame_receiver
  import ffr_pkg::*;
#(
  parameter int unsigned       MAX_IMAGE_BYTES = 262144,
  parameter logic [ADDR_W-1:0] BASE_ADDRESS    = 32'h0000_0000,
  parameter int unsigned       MAX_FRAME_BYTES = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // Input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,  // frame_number[15:0], frame_length[26:16],
                                           // byte_value[34:27], zero pad[39:35]
  input  logic [0:0]             s_tuser,  // operation[0]
  input  logic                   s_tlast,  // last_in_frame
  // Output stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata   // write_enable[0], write_address[32:1],
                                           // write_data[40:33], status[43:41], pad[47:44]
);

  ffr_cfg_t    cfg;
  ffr_item_t   item;
  ffr_result_t result;
  logic        item_valid;
  logic        take;
  logic        out_ready;

  ffr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ffr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  ffr_core #(
    .MAX_IMAGE_BYTES (MAX_IMAGE_BYTES),
    .BASE_ADDRESS    (BASE_ADDRESS),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .out_ready  (out_ready),
    .take       (take),
    .result     (result)
  );

  ffr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .result    (result),
    .out_ready (out_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

>>> src/ffr_checker.sv
// ----------------------------------------------------------------------------
// ffr_checker: port-level checks for the firmware frame receiver
//
// Watches the output stream for held beats, result codes and write
// fields that must agree with the write enable.
// ----------------------------------------------------------------------------
module ffr_checker
  import ffr_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  logic        we;
  logic [40:1] wfields;
  logic [2:0]  status;

  assign we      = m_tdata[0];
  assign wfields = m_tdata[40:1];
  assign status  = m_tdata[43:41];

  // Hold a stalled result beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed while stalled");

  // No result right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Address and data are zero when nothing is written
  a_nowrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !we |-> wfields == '0)
    else $error("write fields set without write enable");

  // A written byte never reports a rejection
  a_write_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && we |-> status == STAT_OK || status == STAT_SUM_MISMATCH ||
                       status == STAT_COMPLETE)
    else $error("write with rejection status");

  // Status stays within the defined codes
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> status <= STAT_COMPLETE)
    else $error("undefined status code");

endmodule

bind firmware_frame_receiver ffr_checker u_ffr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
